@@ hw/rtl/shash_pkg.sv @@
// Shared types, constants and round functions for the SHA-256 byte stream hasher.
package shash_pkg;

  localparam int unsigned BLOCK_BITS = 512;
  localparam int unsigned FILL_W = 7;

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [FILL_W-1:0] LEN_FILL = 7'd56;

  typedef logic [7:0][31:0] hash_t;
  typedef logic [BLOCK_BITS-1:0] block_t;

  typedef struct packed {
    logic start;
    logic init;
  } shash_ctl_t;

  localparam hash_t HASH_IV = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

@@ hw/rtl/shash_core.sv @@
// SHA-256 compression unit: one round per cycle over a shifting message schedule.
module shash_core import shash_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  shash_ctl_t ctl_i,
  input  block_t     block_i,
  output logic       done_o,
  output hash_t      hash_o
);

  typedef enum logic [1:0] {C_IDLE, C_ROUND, C_ADD} core_state_t;

  core_state_t       state_r;
  hash_t             h_r;
  hash_t             v_r;
  logic [15:0][31:0] w_r;
  logic [5:0]        rnd_r;

  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] w_new;

  always_comb begin
    t1 = v_r[7] + big_sig1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
       + ROUND_K[rnd_r] + w_r[0];
    t2 = big_sig0(v_r[0]) + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
    w_new = small_sig1(w_r[14]) + w_r[9] + small_sig0(w_r[1]) + w_r[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      h_r     <= HASH_IV;
      rnd_r   <= '0;
    end else begin
      unique case (state_r)
        C_IDLE: begin
          if (ctl_i.init) begin
            h_r <= HASH_IV;
          end else if (ctl_i.start) begin
            for (int i = 0; i < 16; i++) begin
              w_r[i] <= block_i[BLOCK_BITS-1-32*i -: 32];
            end
            v_r     <= h_r;
            rnd_r   <= '0;
            state_r <= C_ROUND;
          end
        end
        C_ROUND: begin
          for (int i = 0; i < 15; i++) begin
            w_r[i] <= w_r[i+1];
          end
          w_r[15] <= w_new;
          v_r[0]  <= t1 + t2;
          v_r[1]  <= v_r[0];
          v_r[2]  <= v_r[1];
          v_r[3]  <= v_r[2];
          v_r[4]  <= v_r[3] + t1;
          v_r[5]  <= v_r[4];
          v_r[6]  <= v_r[5];
          v_r[7]  <= v_r[6];
          rnd_r   <= rnd_r + 6'd1;
          if (rnd_r == 6'd63) begin
            state_r <= C_ADD;
          end
        end
        C_ADD: begin
          for (int j = 0; j < 8; j++) begin
            h_r[j] <= h_r[j] + v_r[j];
          end
          state_r <= C_IDLE;
        end
        default: begin
          state_r <= C_IDLE;
        end
      endcase
    end
  end

  assign done_o = (state_r == C_ADD);
  assign hash_o = h_r;

endmodule

@@ hw/rtl/sha256_byte_stream_hasher_unit.sv @@
// Top level of the SHA-256 byte stream hasher: byte buffering, padding and digest output.
//
// Channel   Direction  Payload                                     Handshake
// in_       input      data_byte[8], has_byte, end_of_message      in_valid / in_stall
// out_      output     digest_word[32], word_index[3], last_word   out_valid / out_stall
//
// An item that does not complete a 64-byte block is taken without stalling the input.
// An item that completes a block stalls the input while the shared compression unit loads
// the block, runs its rounds and adds the result into the hash, and during the handoff.
// The final item adds the padding bytes (marker, zero bytes, 64-bit length) and one or two
// compressions, then the eight digest words come out one per cycle when out_stall is low.
// Reset is synchronous; afterwards the block accepts a transaction at once.
module sha256_byte_stream_hasher_unit import shash_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_MARK, ST_ZERO, ST_LEN, ST_START, ST_WAIT, ST_OUT
  } state_t;

  state_t            state_r;
  state_t            state_nxt;
  state_t            ret_r;
  state_t            ret_nxt;
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_inc;
  logic [63:0]       bits_r;
  logic [7:0][7:0]   len_bytes;
  block_t            block_r;
  logic [2:0]        idx_r;
  logic              push_en;
  logic [7:0]        push_byte;
  logic              push_full;
  logic              out_done;
  logic              core_done;
  hash_t             hash;
  shash_ctl_t        ctl;

  assign fill_inc  = fill_r + 7'd1;
  assign len_bytes = bits_r;
  assign push_full = push_en && fill_inc[FILL_W-1];
  assign out_done  = (state_r == ST_OUT) && !out_stall && (idx_r == 3'd7);

  always_comb begin
    push_en   = 1'b0;
    push_byte = 8'h00;
    state_nxt = state_r;
    ret_nxt   = ret_r;
    unique case (state_r)
      ST_IDLE: begin
        push_en   = in_valid && in_has_byte;
        push_byte = in_data_byte;
        if (in_valid && in_end_of_message) begin
          state_nxt = ST_MARK;
        end
      end
      ST_MARK: begin
        push_en   = 1'b1;
        push_byte = PAD_MARK;
        state_nxt = ST_ZERO;
      end
      ST_ZERO: begin
        if (fill_r == LEN_FILL) begin
          state_nxt = ST_LEN;
        end else begin
          push_en = 1'b1;
        end
      end
      ST_LEN: begin
        push_en   = 1'b1;
        push_byte = len_bytes[~fill_r[2:0]];
      end
      ST_START: begin
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (core_done) begin
          state_nxt = ret_r;
        end
      end
      ST_OUT: begin
        if (out_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (push_full) begin
      ret_nxt   = (state_r == ST_LEN) ? ST_OUT : state_nxt;
      state_nxt = ST_START;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ret_r   <= ST_IDLE;
      fill_r  <= '0;
      bits_r  <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      if (push_en) begin
        block_r <= {block_r[BLOCK_BITS-9:0], push_byte};
        fill_r  <= push_full ? '0 : fill_inc;
      end
      if (state_r == ST_IDLE && in_valid && in_has_byte) begin
        bits_r <= bits_r + 64'd8;
      end
      if (state_r == ST_OUT && !out_stall) begin
        idx_r <= idx_r + 3'd1;
      end
      if (out_done) begin
        fill_r <= '0;
        bits_r <= '0;
      end
    end
  end

  assign ctl.start = (state_r == ST_START);
  assign ctl.init  = out_done;

  shash_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_i   (ctl),
    .block_i (block_r),
    .done_o  (core_done),
    .hash_o  (hash)
  );

  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = (state_r == ST_OUT);
  assign out_digest_word = hash[idx_r];
  assign out_word_index  = idx_r;
  assign out_last_word   = (idx_r == 3'd7);

endmodule

@@ hw/rtl/shash_checker.sv @@
// Port-level checks for the SHA-256 byte stream hasher and their binding to the top level.
module shash_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_digest_word,
  input logic [2:0]  out_word_index,
  input logic        out_last_word
);

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_word == (out_word_index == 3'd7)))
    else $error("last_word flag does not match the word index");

  a_word_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last_word) |=>
      (out_valid && (out_word_index == $past(out_word_index) + 3'd1)))
    else $error("digest words are not delivered back to back in order");

  a_no_input_during_output: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted while digest words are pending");

  a_stalled_word_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_digest_word)))
    else $error("stalled digest word changed");

endmodule

bind sha256_byte_stream_hasher_unit shash_checker u_shash_checker (.*);
